// ===== rtl/mjd_pkg.sv =====
`default_nettype none

package mjd_pkg;

  // Width of the running byte position; offsets on the result are its low 32 bits
  localparam int unsigned PosBits = 32;

  // Chunk type codes, first byte most significant
  localparam logic [31:0] TypeIdat = 32'h4944_4154;
  localparam logic [31:0] TypeJdat = 32'h4A44_4154;
  localparam logic [31:0] TypeJdaa = 32'h4A44_4141;
  localparam logic [31:0] TypeIend = 32'h4945_4E44;
  localparam logic [31:0] TypeMend = 32'h4D45_4E44;

  // Index of the last byte of each fixed field
  localparam logic [31:0] SigLastIdx   = 32'd7;
  localparam logic [31:0] FieldLastIdx = 32'd3;

  typedef enum logic [2:0] {
    PhSig  = 3'd0,
    PhLen  = 3'd1,
    PhType = 3'd2,
    PhData = 3'd3,
    PhCrc  = 3'd4,
    PhTail = 3'd5,
    PhBad  = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    EvHeader = 2'd0,
    EvClosed = 2'd1,
    EvBadSig = 2'd2,
    EvTrunc  = 2'd3
  } event_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [31:0] chunk_type;
    logic [31:0] chunk_length;
    logic [31:0] chunk_offset;
    logic        continues_run;
    logic        stream_chunk;
    logic        closing_chunk;
    logic        jng_file;
  } out_item_t;

  // Expected MNG signature byte at a given index
  function automatic logic [7:0] sig_mng_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h8A;
      3'd1:    val = 8'h4D;
      3'd2:    val = 8'h4E;
      3'd3:    val = 8'h47;
      3'd4:    val = 8'h0D;
      3'd5:    val = 8'h0A;
      3'd6:    val = 8'h1A;
      default: val = 8'h0A;
    endcase
    return val;
  endfunction

  // Expected JNG signature byte at a given index
  function automatic logic [7:0] sig_jng_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h8B;
      3'd1:    val = 8'h4A;
      3'd2:    val = 8'h4E;
      3'd3:    val = 8'h47;
      3'd4:    val = 8'h0D;
      3'd5:    val = 8'h0A;
      3'd6:    val = 8'h1A;
      default: val = 8'h0A;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mjd_in_reg.sv =====
`default_nettype none

module mjd_in_reg import mjd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_item_i,
  input  wire logic     take_i,
  output logic          valid_o,
  output in_item_t      item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;

  // Accept a new transfer when empty or when the held byte is consumed now
  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the byte until the parser takes it
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ===== rtl/mjd_parser.sv =====
`default_nettype none

module mjd_parser import mjd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,
  input  wire in_item_t item_i,
  output logic          res_valid_o,
  output out_item_t     res_o
);

  phase_e               phase_q, phase_d;
  phase_e               phase_step;
  logic [31:0]          fc_q, fc_d;
  logic                 ok_mng_q, ok_mng_d;
  logic                 ok_jng_q, ok_jng_d;
  logic [31:0]          len_q, len_d;
  logic [31:0]          type_q, type_d;
  logic [31:0]          prev_type_q, prev_type_d;
  logic                 prev_valid_q, prev_valid_d;
  logic [PosBits-1:0]   pos_q, pos_d;
  logic [PosBits-1:0]   start_q, start_d;

  logic [7:0]           b;
  logic                 last;
  logic [PosBits-1:0]   pos_next;
  logic                 ok_mng_upd, ok_jng_upd;
  logic                 jng_now;
  logic [31:0]          close_type;
  logic [31:0]          type_new;
  logic                 strm;
  logic                 fc_is_3;

  assign b        = item_i.data_byte;
  assign last     = item_i.last_byte;
  assign pos_next = pos_q + PosBits'(1);
  assign fc_is_3  = (fc_q == FieldLastIdx);
  assign type_new = {type_q[23:0], b};

  // Signature flags after this byte, used both for state and for the jng flag
  assign ok_mng_upd = (phase_q == PhSig) ? (ok_mng_q && (b == sig_mng_byte(fc_q[2:0])))
                                         : ok_mng_q;
  assign ok_jng_upd = (phase_q == PhSig) ? (ok_jng_q && (b == sig_jng_byte(fc_q[2:0])))
                                         : ok_jng_q;
  assign jng_now    = ok_jng_upd && !ok_mng_upd;
  assign close_type = jng_now ? TypeIend : TypeMend;
  assign strm       = (type_new == TypeIdat) || (type_new == TypeJdat) ||
                      (type_new == TypeJdaa);

  // Next state
  always_comb begin
    phase_d      = phase_q;
    fc_d         = fc_q;
    ok_mng_d     = ok_mng_upd;
    ok_jng_d     = ok_jng_upd;
    len_d        = len_q;
    type_d       = type_q;
    prev_type_d  = prev_type_q;
    prev_valid_d = prev_valid_q;
    pos_d        = pos_next;
    start_d      = start_q;
    case (phase_q)
      PhSig: begin
        if (fc_q == SigLastIdx) begin
          fc_d = '0;
          if (!ok_mng_upd && !ok_jng_upd) begin
            phase_d = PhBad;
          end else begin
            phase_d = PhLen;
            start_d = pos_next;
            len_d   = '0;
            type_d  = '0;
          end
        end else begin
          fc_d = fc_q + 32'd1;
        end
      end
      PhLen: begin
        len_d = {len_q[23:0], b};
        if (fc_is_3) begin
          fc_d    = '0;
          phase_d = PhType;
        end else begin
          fc_d = fc_q + 32'd1;
        end
      end
      PhType: begin
        type_d = type_new;
        if (fc_is_3) begin
          prev_type_d  = type_new;
          prev_valid_d = 1'b1;
          fc_d         = '0;
          phase_d      = (len_q != '0) ? PhData : PhCrc;
        end else begin
          fc_d = fc_q + 32'd1;
        end
      end
      PhData: begin
        if ((fc_q + 32'd1) == len_q) begin
          fc_d    = '0;
          phase_d = PhCrc;
        end else begin
          fc_d = fc_q + 32'd1;
        end
      end
      PhCrc: begin
        if (fc_is_3) begin
          fc_d = '0;
          if (type_q == close_type) begin
            phase_d = PhTail;
          end else begin
            phase_d = PhLen;
            start_d = pos_next;
            len_d   = '0;
            type_d  = '0;
          end
        end else begin
          fc_d = fc_q + 32'd1;
        end
      end
      default: begin
      end
    endcase
    // Phase this byte reaches before any restart on the final byte
    phase_step = phase_d;
    // Final byte returns everything to the reset state
    if (last) begin
      phase_d      = PhSig;
      fc_d         = '0;
      ok_mng_d     = 1'b1;
      ok_jng_d     = 1'b1;
      len_d        = '0;
      type_d       = '0;
      prev_type_d  = '0;
      prev_valid_d = 1'b0;
      pos_d        = '0;
      start_d      = '0;
    end
  end

  // Result for this byte
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    case (phase_q)
      PhSig: begin
        if ((fc_q == SigLastIdx) && !ok_mng_upd && !ok_jng_upd) begin
          res_valid_o     = 1'b1;
          res_o.event_res = EvBadSig;
        end
      end
      PhType: begin
        if (fc_is_3) begin
          res_valid_o         = 1'b1;
          res_o.event_res     = EvHeader;
          res_o.chunk_type    = type_new;
          res_o.chunk_length  = len_q;
          res_o.chunk_offset  = 32'(start_q);
          res_o.stream_chunk  = strm;
          res_o.continues_run = strm && prev_valid_q && (prev_type_q == type_new);
          res_o.closing_chunk = (type_new == close_type);
          res_o.jng_file      = jng_now;
        end
      end
      PhCrc: begin
        if (fc_is_3 && (type_q == close_type)) begin
          res_valid_o         = 1'b1;
          res_o.event_res     = EvClosed;
          res_o.chunk_type    = type_q;
          res_o.chunk_length  = len_q;
          res_o.chunk_offset  = 32'(pos_next);
          res_o.closing_chunk = 1'b1;
          res_o.jng_file      = jng_now;
        end
      end
      default: begin
      end
    endcase
    // Final byte before closure reports truncation instead
    if (last && (phase_step != PhTail) && (phase_step != PhBad)) begin
      res_valid_o    = 1'b1;
      res_o          = '0;
      res_o.event_res = EvTrunc;
      res_o.jng_file = jng_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhSig;
      fc_q         <= '0;
      ok_mng_q     <= 1'b1;
      ok_jng_q     <= 1'b1;
      len_q        <= '0;
      type_q       <= '0;
      prev_type_q  <= '0;
      prev_valid_q <= 1'b0;
      pos_q        <= '0;
      start_q      <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      fc_q         <= fc_d;
      ok_mng_q     <= ok_mng_d;
      ok_jng_q     <= ok_jng_d;
      len_q        <= len_d;
      type_q       <= type_d;
      prev_type_q  <= prev_type_d;
      prev_valid_q <= prev_valid_d;
      pos_q        <= pos_d;
      start_q      <= start_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mjd_out_reg.sv =====
`default_nettype none

module mjd_out_reg import mjd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      load_i,
  input  wire logic      res_valid_i,
  input  wire out_item_t res_i,
  output logic           take_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  logic      valid_q, valid_d;
  out_item_t item_q;
  logic      free;

  // Slot is free when empty or when its result leaves this cycle
  assign free   = !valid_q || out_ready_i;
  assign take_o = in_valid_i && free;

  always_comb begin
    valid_d = valid_q && !out_ready_i;
    if (load_i) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture a result only when the step produced one
  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      item_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

`default_nettype wire

// ===== rtl/mng_jng_chunk_deframer_top.sv =====
// A byte is held in the input register, then its result is registered for the output.
// Throughput: one byte per cycle; a byte advances when the result register is empty
// or drains in the same cycle, so a waiting result stalls the input once the input
// register is full.
// Reset: rst_ni (asynchronous, active low) empties both registers and puts the
// parser in the signature phase at position zero.
`default_nettype none

module mng_jng_chunk_deframer_top import mjd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  logic      held_valid;
  in_item_t  held_item;
  logic      step;
  logic      res_valid;
  out_item_t res;

  // Hold the incoming byte
  mjd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .take_i     (step),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  // Advance the chunk parser one byte
  mjd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (held_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Register the result for the output transfer
  mjd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (held_valid),
    .load_i      (step),
    .res_valid_i (res_valid),
    .res_i       (res),
    .take_o      (step),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
